/* src/tbbq_pkg.sv */
// Shared types and constants for the touch button baseline qualifier.
package tbbq_pkg;

  localparam int RAW_W      = 16;
  localparam int TIME_W     = 32;
  localparam int PCT_W      = 7;
  localparam int CNT_W      = 8;
  localparam int SEC_W      = 23;
  localparam int PROD_W     = RAW_W + PCT_W;
  localparam int SUM_W      = RAW_W + 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Seconds from milliseconds: floor(now * RECIP / 2^RECIP_SHIFT) == now / 1000
  // for every 32-bit now.
  localparam int unsigned     RECIP_SHIFT = 41;
  localparam logic [TIME_W-1:0] RECIP     = 32'd2199023256;

  // Slot remainder: the quotient by a reciprocal on the first step, the
  // remainder from it on the second. The shift holds for windows up to 31 s.
  localparam int SLOT_SHIFT = SEC_W + 5;
  localparam int MOD_STEPS  = 2;
  localparam int STEP_W     = 1;

  localparam logic [6:0]       PCT_SCALE   = 7'd100;
  localparam logic [SUM_W-1:0] ROUND_HALF  = 18'd2;

  localparam logic [PCT_W-1:0] PRESS_PCT_RST   = 7'd80;
  localparam logic [PCT_W-1:0] RELEASE_PCT_RST = 7'd90;
  localparam logic [CNT_W-1:0] CONFIRM_RST     = 8'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_PCT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_PCT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM     = 2'd2;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_MUL  = 9'b000000010,
    ST_MOD  = 9'b000000100,
    ST_RD   = 9'b000001000,
    ST_UPD  = 9'b000010000,
    ST_SCAN = 9'b000100000,
    ST_TAIL = 9'b001000000,
    ST_PROD = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic mod_step;
    logic bkt_rd;
    logic bkt_upd;
    logic scan_rd;
    logic prod;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic arm_next;
    logic scan_last;
  } status_t;

  typedef struct packed {
    logic [PCT_W-1:0] press_pct;
    logic [PCT_W-1:0] release_pct;
    logic [CNT_W-1:0] confirm;
  } cfg_t;

  typedef struct packed {
    logic              result_channel;
    logic              armed;
    logic              press_event;
    logic              release_event;
    logic              is_pressed;
    logic [TIME_W-1:0] hold_ms;
    logic [RAW_W-1:0]  baseline;
  } result_t;

endpackage

/* src/tbbq_in_if.sv */
// Sample channel: valid/ready handshake with the raw count payload.
interface tbbq_in_if;
  import tbbq_pkg::*;

  logic              valid;
  logic              ready;
  logic              channel;
  logic [RAW_W-1:0]  raw_count;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, channel, raw_count, now_ms, input ready);
  modport sink   (input valid, channel, raw_count, now_ms, output ready);
endinterface

/* src/tbbq_out_if.sv */
// Result channel: valid/ready handshake with the qualified button status.
interface tbbq_out_if;
  import tbbq_pkg::*;

  logic              valid;
  logic              ready;
  logic              result_channel;
  logic              armed;
  logic              press_event;
  logic              release_event;
  logic              is_pressed;
  logic [TIME_W-1:0] hold_ms;
  logic [RAW_W-1:0]  baseline;

  modport source (output valid, result_channel, armed, press_event, release_event,
                  is_pressed, hold_ms, baseline, input ready);
  modport sink   (input valid, result_channel, armed, press_event, release_event,
                  is_pressed, hold_ms, baseline, output ready);
endinterface

/* src/touch_button_baseline_qualifier_top.sv */
// Top level of the touch button baseline qualifier.
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+-----------------------------------------------
//  in_bus   | in  | valid / ready   | channel, raw_count, now_ms
//  out_bus  | out | valid / ready   | result_channel, armed, press_event,
//           |     |                 | release_event, is_pressed, hold_ms, baseline
//  cfg_*    | in  | cfg_we only     | cfg_index, cfg_wdata (no read-back)
//
// Once armed, a result is loaded into the output register after its accepted
// sample beat has passed states MUL, MOD, RD, UPD, SCAN, TAIL, PROD and DONE;
// while unarmed, UPD goes straight to DONE. Its beat can leave, and the next
// sample beat be taken, in the cycle after the load. The baseline scan makes one
// ring read per cycle through the maxima RAM's single read port; the slot remainder
// adds two steps (reciprocal quotient, then remainder). rst_n is synchronous: it
// clears control, filter state and configuration (80, 90, 3). The ring RAM is
// not cleared. A finished result waits in the output register while the next
// sample is accepted; a stalled sink only holds the controller in its final state.
module touch_button_baseline_qualifier_top #(
  parameter int WINDOW_SECONDS = 16,
  parameter int CHANNELS       = 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  tbbq_in_if.sink                          in_bus,
  tbbq_out_if.source                       out_bus,
  input  logic                             cfg_we,
  input  logic [tbbq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tbbq_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tbbq_pkg::*;

  cfg_t    cfg_r;
  cmd_t    cmd;
  status_t status;
  result_t result;
  result_t out_r;
  logic    out_valid_r;
  logic    out_free;

  // Configuration registers: take a write whenever the enable is high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_pct   <= PRESS_PCT_RST;
      cfg_r.release_pct <= RELEASE_PCT_RST;
      cfg_r.confirm     <= CONFIRM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRESS_PCT:   cfg_r.press_pct   <= cfg_wdata[PCT_W-1:0];
        CFG_RELEASE_PCT: cfg_r.release_pct <= cfg_wdata[PCT_W-1:0];
        CFG_CONFIRM:     cfg_r.confirm     <= cfg_wdata[CNT_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // The output register is free when empty or when its beat leaves this cycle.
  assign out_free = !out_valid_r || out_bus.ready;

  tbbq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd)
  );

  tbbq_dp #(
    .WINDOW_SECONDS (WINDOW_SECONDS),
    .CHANNELS       (CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .cfg        (cfg_r),
    .in_channel (in_bus.channel),
    .in_raw     (in_bus.raw_count),
    .in_now     (in_bus.now_ms),
    .result     (result)
  );

  // Load the result on commit; hold it until the sink takes the beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_r <= result;
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.result_channel = out_r.result_channel;
  assign out_bus.armed          = out_r.armed;
  assign out_bus.press_event    = out_r.press_event;
  assign out_bus.release_event  = out_r.release_event;
  assign out_bus.is_pressed     = out_r.is_pressed;
  assign out_bus.hold_ms        = out_r.hold_ms;
  assign out_bus.baseline       = out_r.baseline;
endmodule

/* src/tbbq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tbbq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/tbbq_ctrl.sv */
// Controller state machine sequencing one sample through the datapath.
module tbbq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_free,
  input  tbbq_pkg::status_t status,
  output tbbq_pkg::cmd_t    cmd
);
  import tbbq_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        step_nxt  = '0;
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(MOD_STEPS - 1)) state_nxt = ST_RD;
      end
      ST_RD:   state_nxt = ST_UPD;
      ST_UPD:  state_nxt = status.arm_next ? ST_SCAN : ST_DONE;
      ST_SCAN: begin
        if (status.scan_last) state_nxt = ST_TAIL;
      end
      ST_TAIL: state_nxt = ST_PROD;
      ST_PROD: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign in_ready     = (state_r == ST_IDLE);
  assign cmd.load     = (state_r == ST_IDLE) && in_valid;
  assign cmd.mul      = (state_r == ST_MUL);
  assign cmd.mod_step = (state_r == ST_MOD);
  assign cmd.bkt_rd   = (state_r == ST_RD);
  assign cmd.bkt_upd  = (state_r == ST_UPD);
  assign cmd.scan_rd  = (state_r == ST_SCAN);
  assign cmd.prod     = (state_r == ST_PROD);
  assign cmd.commit   = (state_r == ST_DONE) && out_free;
endmodule

/* src/tbbq_dp.sv */
// Datapath: per-channel filter state, second-maxima ring, thresholds.
module tbbq_dp #(
  parameter int WINDOW_SECONDS = 16,
  parameter int CHANNELS       = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tbbq_pkg::cmd_t                 cmd,
  output tbbq_pkg::status_t              status,
  input  tbbq_pkg::cfg_t                 cfg,
  input  logic                           in_channel,
  input  logic [tbbq_pkg::RAW_W-1:0]     in_raw,
  input  logic [tbbq_pkg::TIME_W-1:0]    in_now,
  output tbbq_pkg::result_t              result
);
  import tbbq_pkg::*;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH  = CHANNELS * WINDOW_SECONDS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W = (WINDOW_SECONDS > 1) ? $clog2(WINDOW_SECONDS) : 1;
  localparam int FILL_W = $clog2(WINDOW_SECONDS + 1);
  localparam int QP_W   = SEC_W + SLOT_SHIFT + 1;
  localparam logic [SLOT_SHIFT:0] SLOT_RECIP = (SLOT_SHIFT + 1)'(
    ((64'd1 << SLOT_SHIFT) + 64'(WINDOW_SECONDS - 1)) / 64'(WINDOW_SECONDS));
  localparam logic [FILL_W-1:0] WIN_F   = FILL_W'(WINDOW_SECONDS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_SECONDS - 1);

  // Sample capture
  logic              in_ch_r;
  logic [CH_W-1:0]   ch_r;
  logic [RAW_W-1:0]  raw_r;
  logic [TIME_W-1:0] now_r;

  // Seconds and slot
  logic [2*TIME_W-1:0] sec_prod;
  logic [SEC_W-1:0]    sec_r;
  logic [QP_W-1:0]     quo_prod;
  logic [SEC_W-1:0]    quo_r;
  logic [SEC_W-1:0]    rem_full;
  logic [SLOT_W-1:0]   rem_r;

  // Per-channel state
  logic [RAW_W-1:0]  smooth_r    [CHANNELS];
  logic [FILL_W-1:0] filled_r    [CHANNELS];
  logic [SEC_W-1:0]  last_sec_r  [CHANNELS];
  logic              pressed_r   [CHANNELS];
  logic [TIME_W-1:0] press_t0_r  [CHANNELS];
  logic [CNT_W-1:0]  low_run_r   [CHANNELS];

  // Ring access
  logic [SLOT_W-1:0] scan_idx_r;
  logic              scan_vld_r;
  logic [RAW_W-1:0]  scan_max_r;
  logic [ADDR_W-1:0] row_base, cell_addr, raddr;
  logic [RAW_W-1:0]  rdata;
  logic              ram_we;

  // Bucket update
  logic [SUM_W-1:0]  smooth_sum;
  logic [RAW_W-1:0]  smooth_new;
  logic              first;
  logic              new_sec;
  logic [FILL_W-1:0] filled_new;

  // Threshold products
  logic [PROD_W-1:0] r100_r, bp_r, br_r;

  // Decision
  logic              armed, below, above;
  logic [RAW_W-1:0]  base;
  logic [CNT_W-1:0]  run_inc;
  logic              press_ev, release_ev, pressed_new;
  logic [TIME_W-1:0] hold;

  // ---------------- capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_ch_r <= in_channel;
      ch_r    <= (CHANNELS > 1) ? CH_W'(in_channel) : '0;
      raw_r   <= in_raw;
      now_r   <= in_now;
    end
  end

  // ---------------- seconds and slot, both by reciprocal
  assign sec_prod = 64'(now_r) * 64'(RECIP);
  assign quo_prod = QP_W'(sec_r) * QP_W'(SLOT_RECIP);
  assign rem_full = sec_r - quo_r * SEC_W'(WINDOW_SECONDS);

  // The first mod step forms the quotient, the second the remainder from it.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      sec_r <= sec_prod[RECIP_SHIFT +: SEC_W];
    end else if (cmd.mod_step) begin
      quo_r <= quo_prod[SLOT_SHIFT +: SEC_W];
      rem_r <= rem_full[SLOT_W-1:0];
    end
  end

  // ---------------- ring addressing
  assign row_base  = ADDR_W'(ch_r) * ADDR_W'(WINDOW_SECONDS);
  assign cell_addr = row_base + ADDR_W'(rem_r);
  assign raddr     = cmd.bkt_rd ? cell_addr : (row_base + ADDR_W'(scan_idx_r));

  // ---------------- smoothing and bucket update
  assign first      = (filled_r[ch_r] == '0);
  assign smooth_sum = SUM_W'(smooth_r[ch_r]) + SUM_W'({smooth_r[ch_r], 1'b0})
                      + SUM_W'(raw_r) + ROUND_HALF;
  assign smooth_new = first ? raw_r : smooth_sum[SUM_W-1:2];
  assign new_sec    = (sec_r != last_sec_r[ch_r]) || first;
  assign filled_new = (new_sec && (filled_r[ch_r] < WIN_F)) ?
                      filled_r[ch_r] + FILL_W'(1) : filled_r[ch_r];
  assign ram_we     = cmd.bkt_upd && (new_sec || (smooth_new > rdata));

  tbbq_ram #(
    .WIDTH (RAW_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cell_addr),
    .wdata (smooth_new),
    .raddr (raddr),
    .rdata (rdata)
  );

  // ---------------- baseline scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_vld_r <= 1'b0;
    end else begin
      scan_vld_r <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bkt_upd) begin
      scan_idx_r <= '0;
      scan_max_r <= '0;
    end else begin
      if (cmd.scan_rd) scan_idx_r <= scan_idx_r + SLOT_W'(1);
      if (scan_vld_r && (rdata > scan_max_r)) scan_max_r <= rdata;
    end
  end

  assign status.arm_next  = (filled_new >= WIN_F);
  assign status.scan_last = (scan_idx_r == SLOT_LAST);

  // ---------------- threshold products
  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      r100_r <= PROD_W'(raw_r) * PROD_W'(PCT_SCALE);
      bp_r   <= PROD_W'(scan_max_r) * PROD_W'(cfg.press_pct);
      br_r   <= PROD_W'(scan_max_r) * PROD_W'(cfg.release_pct);
    end
  end

  // ---------------- press / release decision
  assign armed   = (filled_r[ch_r] >= WIN_F);
  assign base    = armed ? scan_max_r : '0;
  assign below   = (base != '0) && (r100_r <= bp_r);
  assign above   = (base == '0) || (r100_r >= br_r);
  assign run_inc = below ? low_run_r[ch_r] + CNT_W'(1) : '0;

  always_comb begin
    press_ev    = 1'b0;
    release_ev  = 1'b0;
    hold        = '0;
    pressed_new = pressed_r[ch_r];
    if (armed) begin
      if (!pressed_r[ch_r]) begin
        if (run_inc >= cfg.confirm) begin
          press_ev    = 1'b1;
          pressed_new = 1'b1;
        end
      end else if (above) begin
        release_ev  = 1'b1;
        pressed_new = 1'b0;
        hold        = now_r - press_t0_r[ch_r];
      end
    end
  end

  assign result.result_channel = in_ch_r;
  assign result.armed          = armed;
  assign result.press_event    = press_ev;
  assign result.release_event  = release_ev;
  assign result.is_pressed     = pressed_new;
  assign result.hold_ms        = hold;
  assign result.baseline       = base;

  // ---------------- per-channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        smooth_r[c]   <= '0;
        filled_r[c]   <= '0;
        last_sec_r[c] <= '0;
        pressed_r[c]  <= 1'b0;
        press_t0_r[c] <= '0;
        low_run_r[c]  <= '0;
      end
    end else begin
      if (cmd.bkt_upd) begin
        smooth_r[ch_r] <= smooth_new;
        filled_r[ch_r] <= filled_new;
        if (new_sec) last_sec_r[ch_r] <= sec_r;
      end
      if (cmd.commit && armed) begin
        pressed_r[ch_r] <= pressed_new;
        if (!pressed_r[ch_r]) begin
          low_run_r[ch_r] <= press_ev ? '0 : run_inc;
          if (press_ev) press_t0_r[ch_r] <= now_r;
        end
      end
    end
  end
endmodule

/* src/tbbq_checker.sv */
// Port-level checker for the qualifier, bound to the top level.
module tbbq_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_armed,
  input logic        out_press_event,
  input logic        out_release_event,
  input logic        out_is_pressed,
  input logic [31:0] out_hold_ms,
  input logic [15:0] out_baseline
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hold_ms)
      && $stable(out_baseline) && $stable(out_is_pressed))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted while previous one still in work");

  a_unarmed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_armed |-> !out_press_event && !out_release_event
      && (out_hold_ms == 32'd0) && (out_baseline == 16'd0))
    else $error("unarmed result carries an event or baseline");

  a_event_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_press_event || out_release_event) |->
      (out_press_event != out_release_event) && (out_is_pressed == out_press_event))
    else $error("event disagrees with pressed state");

  a_hold_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_hold_ms != 32'd0) |-> out_release_event)
    else $error("hold time reported without a release");

endmodule

bind touch_button_baseline_qualifier_top tbbq_props u_tbbq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_bus.valid),
  .in_ready          (in_bus.ready),
  .out_valid         (out_bus.valid),
  .out_ready         (out_bus.ready),
  .out_armed         (out_bus.armed),
  .out_press_event   (out_bus.press_event),
  .out_release_event (out_bus.release_event),
  .out_is_pressed    (out_bus.is_pressed),
  .out_hold_ms       (out_bus.hold_ms),
  .out_baseline      (out_bus.baseline)
);
